FILE: src/rrmf_pkg.sv
// Shared types, codes and sizes for the range-routed message FIFOs.
package rrmf_pkg;

    // Default sizes
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_NUM_QUEUES  = 4;

    // Configuration register file: two registers per queue slot
    localparam int MAX_QUEUES  = 4;
    localparam int CFG_COUNT   = 2 * MAX_QUEUES;
    localparam int CFG_IDX_W   = $clog2(CFG_COUNT);
    localparam int CFG_DATA_W  = 32;
    localparam logic CFG_SEL_FIRST = 1'b0;
    localparam logic CFG_SEL_LAST  = 1'b1;

    // Field widths
    localparam int QID_W     = 2;
    localparam int TYPE_W    = 32;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 32;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [0:0] {
        OP_DELIVER = 1'b0,
        OP_RECEIVE = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        OUT_QUEUED   = 3'd0,
        OUT_FULL     = 3'd1,
        OUT_NOMATCH  = 3'd2,
        OUT_RECEIVED = 3'd3,
        OUT_EMPTY    = 3'd4
    } t_outcome;

    typedef struct packed {
        t_opcode               opcode;
        logic [QID_W-1:0]      queue_select;
        logic [TYPE_W-1:0]     msg_type;
        logic [PAYLOAD_W-1:0]  payload;
        logic [STATUS_W-1:0]   status_word;
    } t_req;

    typedef struct packed {
        t_outcome              outcome;
        logic [QID_W-1:0]      queue_used;
        logic [TYPE_W-1:0]     out_type;
        logic [PAYLOAD_W-1:0]  out_payload;
        logic [STATUS_W-1:0]   out_status;
    } t_rsp;

    // Classified command handed from front to back
    typedef struct packed {
        t_opcode               opcode;
        logic                  hit;      // a queue exists for this command
        logic [QID_W-1:0]      qid;
        logic [TYPE_W-1:0]     msg_type;
        logic [PAYLOAD_W-1:0]  payload;
        logic [STATUS_W-1:0]   status_word;
    } t_cmd;

    // Command queue status seen by front and top
    typedef struct packed {
        logic full;
        logic empty;
    } t_cmdq_stat;

endpackage

FILE: src/rrmf_front.sv
// Front end: range registers and routing of each request to a queue.
module rrmf_front #(
    parameter int NUM_QUEUES = rrmf_pkg::DEF_NUM_QUEUES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rrmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_start,
    input  rrmf_pkg::t_req                  i_req,
    input  rrmf_pkg::t_cmdq_stat            i_qstat,
    output logic                            o_push,
    output rrmf_pkg::t_cmd                  o_cmd
);

    localparam int SLOT_W = rrmf_pkg::CFG_IDX_W - 1;

    logic [rrmf_pkg::TYPE_W-1:0] r_first [rrmf_pkg::MAX_QUEUES];
    logic [rrmf_pkg::TYPE_W-1:0] r_last  [rrmf_pkg::MAX_QUEUES];

    logic [SLOT_W-1:0]          cfg_slot;
    logic                       route_hit;
    logic [rrmf_pkg::QID_W-1:0] route_qid;

    assign cfg_slot = i_cfg_index[rrmf_pkg::CFG_IDX_W-1:1];

    // Range registers; reset leaves every queue disabled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < rrmf_pkg::MAX_QUEUES; q++) begin
                r_first[q] <= rrmf_pkg::TYPE_W'(1);
                r_last[q]  <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index[0] == rrmf_pkg::CFG_SEL_LAST) begin
                r_last[cfg_slot] <= i_cfg_data;
            end else begin
                r_first[cfg_slot] <= i_cfg_data;
            end
        end
    end

    // Range match: later (higher) queues override lower ones
    always_comb begin
        route_hit = 1'b0;
        route_qid = '0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            if (i_req.msg_type >= r_first[q] && i_req.msg_type <= r_last[q]) begin
                route_hit = 1'b1;
                route_qid = rrmf_pkg::QID_W'(q);
            end
        end
    end

    // Build the classified command
    always_comb begin
        o_cmd.opcode      = i_req.opcode;
        o_cmd.msg_type    = i_req.msg_type;
        o_cmd.payload     = i_req.payload;
        o_cmd.status_word = i_req.status_word;
        if (i_req.opcode == rrmf_pkg::OP_RECEIVE) begin
            o_cmd.qid = i_req.queue_select;
            o_cmd.hit = (32'(i_req.queue_select) < 32'(NUM_QUEUES));
        end else begin
            o_cmd.qid = route_qid;
            o_cmd.hit = route_hit;
        end
    end

    assign o_push = i_start && !i_qstat.full;

endmodule

FILE: src/rrmf_cmdq.sv
// Short command queue between the front and back ends.
module rrmf_cmdq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rrmf_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output rrmf_pkg::t_cmd       o_cmd,
    output rrmf_pkg::t_cmdq_stat o_stat
);

    localparam int PW = $clog2(rrmf_pkg::CMDQ_DEPTH);
    localparam int CW = $clog2(rrmf_pkg::CMDQ_DEPTH + 1);

    rrmf_pkg::t_cmd r_slot [rrmf_pkg::CMDQ_DEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(rrmf_pkg::CMDQ_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = bump(r_wp);
        end
        if (i_pop) begin
            n_rp = bump(r_rp);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    assign o_cmd        = r_slot[r_rp];
    assign o_stat.full  = (r_cnt == CW'(rrmf_pkg::CMDQ_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

FILE: src/rrmf_back.sv
// Back end: per-queue pointers, message memory and result register.
module rrmf_back #(
    parameter int QUEUE_DEPTH = rrmf_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_QUEUES  = rrmf_pkg::DEF_NUM_QUEUES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rrmf_pkg::t_cmd  i_cmd,
    output logic            o_done,
    output rrmf_pkg::t_rsp  o_rsp
);

    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);

    logic [PW-1:0] r_wp  [NUM_QUEUES];
    logic [PW-1:0] r_rp  [NUM_QUEUES];
    logic [CW-1:0] r_cnt [NUM_QUEUES];

    logic [rrmf_pkg::TYPE_W-1:0]    r_mem_type    [MEM_DEPTH];
    logic [rrmf_pkg::PAYLOAD_W-1:0] r_mem_payload [MEM_DEPTH];
    logic [rrmf_pkg::STATUS_W-1:0]  r_mem_status  [MEM_DEPTH];

    logic [rrmf_pkg::TYPE_W-1:0]    r_rd_type;
    logic [rrmf_pkg::PAYLOAD_W-1:0] r_rd_payload;
    logic [rrmf_pkg::STATUS_W-1:0]  r_rd_status;

    logic                       r_done;
    rrmf_pkg::t_outcome         r_outcome, n_outcome;
    logic [rrmf_pkg::QID_W-1:0] r_queue;

    logic [PW-1:0] sel_wp, sel_rp;
    logic [CW-1:0] sel_cnt;
    logic          do_push, do_pop;
    logic [AW-1:0] addr;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Pick the addressed queue's pointers
    always_comb begin
        sel_wp  = '0;
        sel_rp  = '0;
        sel_cnt = '0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            if (i_cmd.qid == rrmf_pkg::QID_W'(q)) begin
                sel_wp  = r_wp[q];
                sel_rp  = r_rp[q];
                sel_cnt = r_cnt[q];
            end
        end
    end

    // Decide the outcome of the command at the head of the queue
    always_comb begin
        do_push = 1'b0;
        do_pop  = 1'b0;
        if (i_cmd.opcode == rrmf_pkg::OP_RECEIVE) begin
            if (!i_cmd.hit || sel_cnt == '0) begin
                n_outcome = rrmf_pkg::OUT_EMPTY;
            end else begin
                n_outcome = rrmf_pkg::OUT_RECEIVED;
                do_pop    = i_valid;
            end
        end else begin
            if (!i_cmd.hit) begin
                n_outcome = rrmf_pkg::OUT_NOMATCH;
            end else if (sel_cnt == CW'(QUEUE_DEPTH)) begin
                n_outcome = rrmf_pkg::OUT_FULL;
            end else begin
                n_outcome = rrmf_pkg::OUT_QUEUED;
                do_push   = i_valid;
            end
        end
    end

    // Flat memory address: queue base plus slot
    assign addr = AW'(i_cmd.qid) * AW'(QUEUE_DEPTH)
                + AW'(do_push ? sel_wp : sel_rp);

    // Per-queue pointer and fill count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_wp[q]  <= '0;
                r_rp[q]  <= '0;
                r_cnt[q] <= '0;
            end
        end else begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                if (i_cmd.qid == rrmf_pkg::QID_W'(q)) begin
                    if (do_push) begin
                        r_wp[q]  <= bump(r_wp[q]);
                        r_cnt[q] <= r_cnt[q] + CW'(1);
                    end else if (do_pop) begin
                        r_rp[q]  <= bump(r_rp[q]);
                        r_cnt[q] <= r_cnt[q] - CW'(1);
                    end
                end
            end
        end
    end

    // Message memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem_type[addr]    <= i_cmd.msg_type;
            r_mem_payload[addr] <= i_cmd.payload;
            r_mem_status[addr]  <= i_cmd.status_word;
        end else if (do_pop) begin
            r_rd_type    <= r_mem_type[addr];
            r_rd_payload <= r_mem_payload[addr];
            r_rd_status  <= r_mem_status[addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_outcome <= n_outcome;
            r_queue   <= (n_outcome == rrmf_pkg::OUT_NOMATCH) ? '0 : i_cmd.qid;
        end
    end

    // Data fields are zero unless a message was popped
    always_comb begin
        o_rsp.outcome     = r_outcome;
        o_rsp.queue_used  = r_queue;
        o_rsp.out_type    = '0;
        o_rsp.out_payload = '0;
        o_rsp.out_status  = '0;
        if (r_outcome == rrmf_pkg::OUT_RECEIVED) begin
            o_rsp.out_type    = r_rd_type;
            o_rsp.out_payload = r_rd_payload;
            o_rsp.out_status  = r_rd_status;
        end
    end

    assign o_done = r_done;

endmodule

FILE: src/range_routed_message_fifos.sv
// Top level of the range-routed message FIFOs.
// One request (deliver or receive) is taken per clock while busy is low,
// and each request gives exactly one result, strobed on o_done for a single
// cycle. The command queue registers the request when it is accepted; the
// back end then pops it, updates pointers and memory and registers the
// result, and o_done is driven from that result register. Sustained rate is
// one request per cycle, set by the single-port message memory and
// per-queue pointer update in the back end. Results must be captured when
// o_done is high; there is no output stall. The user must write the range
// registers through i_cfg_we only while no request is in flight; the block
// does not enforce this. A deliver goes to the highest-numbered queue whose
// inclusive type range holds msg_type.
module range_routed_message_fifos #(
    parameter int QUEUE_DEPTH = rrmf_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_QUEUES  = rrmf_pkg::DEF_NUM_QUEUES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rrmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  rrmf_pkg::t_req                  i_req,
    output logic                            o_done,
    output rrmf_pkg::t_rsp                  o_rsp
);

    logic                 push;
    rrmf_pkg::t_cmd       front_cmd;
    rrmf_pkg::t_cmd       head_cmd;
    rrmf_pkg::t_cmdq_stat qstat;
    logic                 pop;

    rrmf_front #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_start     (start),
        .i_req       (i_req),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    rrmf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (qstat)
    );

    // Back end never stalls, so the head command is always taken
    assign pop  = !qstat.empty;
    assign busy = qstat.full;

    rrmf_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_QUEUES  (NUM_QUEUES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pop),
        .i_cmd   (head_cmd),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // Every result comes from a command popped the cycle before
    a_done_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(pop))
        else $error("result without a popped command");

    // A taken request is in the command queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !qstat.empty)
        else $error("accepted request missing from command queue");

    // Only a received message carries data
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.outcome != rrmf_pkg::OUT_RECEIVED) |->
        (o_rsp.out_type == '0 && o_rsp.out_payload == '0 && o_rsp.out_status == '0))
        else $error("data on a result that popped nothing");

endmodule
